>>> rtl/rlevd_pkg.sv
// Shared types, codes and helpers of the run-length video-memory stream decoder.
package rlevd_pkg;

  localparam int STORE_DEPTH = 16384;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [ADDR_W-1:0] ADDR_MAX    = ADDR_W'(STORE_DEPTH - 1);
  localparam logic [ADDR_W-1:0] PAL_BASE    = 14'h3F00;
  localparam logic [ADDR_W-1:0] PAL_SEL     = 14'h001F;
  localparam logic [ADDR_W-1:0] PAL_TEST    = 14'h0013;
  localparam logic [ADDR_W-1:0] PAL_HIT     = 14'h0010;

  localparam logic [7:0]  CMD_END   = 8'hFF;
  localparam logic [7:0]  CMD_ADDR  = 8'h7F;
  localparam logic [7:0]  CMD_COPY  = 8'h80;
  localparam logic [8:0]  RUN_MAX   = 9'd256;
  localparam logic [14:0] COUNT_MAX = 15'h7FFF;

  // Stream decode phase
  typedef enum logic [2:0] {
    PH_HDR_LO = 3'd0,
    PH_HDR_HI = 3'd1,
    PH_CMD    = 3'd2,
    PH_ADR_LO = 3'd3,
    PH_ADR_HI = 3'd4,
    PH_COPY   = 3'd5,
    PH_REPEAT = 3'd6
  } phase_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_MORE  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2,
    ST_READ  = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    SQ_CLEAR  = 3'd0,
    SQ_IDLE   = 3'd1,
    SQ_READ   = 3'd2,
    SQ_WRITE  = 3'd3,
    SQ_MIRROR = 3'd4,
    SQ_FINISH = 3'd5
  } seq_t;

  // Palette mirror entry for a write address in the palette area
  function automatic logic [ADDR_W-1:0] mirror_addr(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] p;
    p = PAL_BASE | (a & PAL_SEL);
    if ((p & PAL_TEST) == PAL_HIT) begin
      p = p & ~PAL_HIT;
    end
    return p;
  endfunction

endpackage

>>> rtl/rle_video_memory_stream_decoder_top.sv
// Run-length video-memory stream decoder: sequencer, decode state and store.
// Read word: accept with the address on the store port, RAM read, result load.
// Stream word: straight to the result when it writes nothing; otherwise one store
//   write per byte, each followed by a mirror write when the address is in the
//   palette area, so a repeat of n bytes makes n store writes plus their mirrors.
// One word at a time; a finished result waits in the output register.
// After reset a clearing pass zeroes the 16384-byte store,
//   with in_stall high throughout.
module rle_video_memory_stream_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_stream_byte,
  input  logic [13:0] in_bytes_left,
  input  logic [13:0] in_read_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [14:0] out_consumed,
  output logic [7:0]  out_read_data
);

  rlevd_pkg::seq_t    state_r, state_nxt;
  rlevd_pkg::phase_t  phase_r, phase_nxt;
  logic [13:0]        wp_r, wp_nxt;
  logic [8:0]         run_r, run_nxt;
  logic [7:0]         pend_r, pend_nxt;
  logic [14:0]        bc_r, bc_nxt;
  logic [8:0]         cnt_r, cnt_nxt;
  logic [7:0]         byte_r, byte_nxt;
  logic [13:0]        mir_r, mir_nxt;
  rlevd_pkg::status_t res_status_r, res_status_nxt;
  logic [14:0]        res_consumed_r, res_consumed_nxt;
  logic [7:0]         res_data_r, res_data_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [14:0]        out_consumed_r, out_consumed_nxt;
  logic [7:0]         out_read_data_r, out_read_data_nxt;

  logic        in_acc;
  logic        out_free;
  logic        ram_we;
  logic [13:0] ram_addr;
  logic [7:0]  ram_wdata;
  logic [7:0]  ram_rdata;

  // Decode results for the accepted stream word
  rlevd_pkg::phase_t  dec_phase;
  rlevd_pkg::status_t dec_status;
  logic [13:0]        dec_wp;
  logic [8:0]         dec_run;
  logic [8:0]         dec_run_left;
  logic [7:0]         dec_pend;
  logic [14:0]        dec_bc;
  logic [14:0]        dec_count;
  logic [14:0]        dec_consumed;
  logic [8:0]         dec_need;
  logic [8:0]         dec_writes;

  assign in_stall = (state_r != rlevd_pkg::SQ_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_consumed  = out_consumed_r;
  assign out_read_data = out_read_data_r;

  // Decode one stream word against the current phase
  always_comb begin
    dec_phase    = phase_r;
    dec_status   = rlevd_pkg::ST_MORE;
    dec_wp       = wp_r;
    dec_run      = run_r;
    dec_run_left = '0;
    dec_pend     = pend_r;
    dec_consumed = '0;
    dec_need     = 9'd1;
    dec_writes   = '0;
    dec_count    = (bc_r == rlevd_pkg::COUNT_MAX) ? bc_r : bc_r + 15'd1;
    dec_bc       = dec_count;
    case (phase_r)
      rlevd_pkg::PH_HDR_HI, rlevd_pkg::PH_ADR_HI: begin
        dec_wp    = {in_stream_byte[5:0], pend_r};
        dec_phase = rlevd_pkg::PH_CMD;
      end
      rlevd_pkg::PH_ADR_LO: begin
        dec_pend  = in_stream_byte;
        dec_phase = rlevd_pkg::PH_ADR_HI;
      end
      rlevd_pkg::PH_CMD: begin
        if (in_stream_byte == rlevd_pkg::CMD_END) begin
          dec_status   = rlevd_pkg::ST_DONE;
          dec_consumed = dec_count;
          dec_need     = '0;
        end else if (in_stream_byte == rlevd_pkg::CMD_ADDR) begin
          dec_phase = rlevd_pkg::PH_ADR_LO;
          dec_need  = 9'd2;
        end else if ((in_stream_byte & rlevd_pkg::CMD_COPY) != 8'd0) begin
          dec_run   = (in_stream_byte[6:0] == 7'd0) ? rlevd_pkg::RUN_MAX
                                                    : {2'b00, in_stream_byte[6:0]};
          dec_phase = rlevd_pkg::PH_COPY;
          dec_need  = dec_run;
        end else begin
          dec_run   = (in_stream_byte == 8'd0) ? rlevd_pkg::RUN_MAX
                                               : {1'b0, in_stream_byte};
          dec_phase = rlevd_pkg::PH_REPEAT;
        end
      end
      rlevd_pkg::PH_COPY: begin
        dec_writes   = 9'd1;
        dec_run_left = (run_r == 9'd0) ? 9'd0 : run_r - 9'd1;
        dec_run      = dec_run_left;
        if (dec_run_left == 9'd0) begin
          dec_phase = rlevd_pkg::PH_CMD;
        end else begin
          dec_need = dec_run_left;
        end
      end
      rlevd_pkg::PH_REPEAT: begin
        dec_writes = run_r;
        dec_run    = '0;
        dec_phase  = rlevd_pkg::PH_CMD;
      end
      default: begin
        // header low byte, and the unused phase code
        dec_pend  = in_stream_byte;
        dec_phase = rlevd_pkg::PH_HDR_HI;
      end
    endcase
    if (dec_status != rlevd_pkg::ST_DONE && {5'd0, dec_need} > in_bytes_left) begin
      dec_status = rlevd_pkg::ST_ERROR;
    end
    if (dec_status != rlevd_pkg::ST_MORE) begin
      dec_phase = rlevd_pkg::PH_HDR_LO;
      dec_bc    = '0;
      dec_run   = '0;
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rlevd_pkg::SQ_CLEAR: begin
        if (wp_r == rlevd_pkg::ADDR_MAX) begin
          state_nxt = rlevd_pkg::SQ_IDLE;
        end
      end
      rlevd_pkg::SQ_IDLE: begin
        if (in_acc) begin
          if (in_cmd) begin
            state_nxt = rlevd_pkg::SQ_READ;
          end else if (dec_writes != 9'd0) begin
            state_nxt = rlevd_pkg::SQ_WRITE;
          end else begin
            state_nxt = rlevd_pkg::SQ_FINISH;
          end
        end
      end
      rlevd_pkg::SQ_READ: begin
        state_nxt = rlevd_pkg::SQ_FINISH;
      end
      rlevd_pkg::SQ_WRITE: begin
        if (wp_r >= rlevd_pkg::PAL_BASE) begin
          state_nxt = rlevd_pkg::SQ_MIRROR;
        end else if (cnt_r == 9'd1) begin
          state_nxt = rlevd_pkg::SQ_FINISH;
        end
      end
      rlevd_pkg::SQ_MIRROR: begin
        state_nxt = (cnt_r == 9'd0) ? rlevd_pkg::SQ_FINISH : rlevd_pkg::SQ_WRITE;
      end
      rlevd_pkg::SQ_FINISH: begin
        if (out_free) begin
          state_nxt = rlevd_pkg::SQ_IDLE;
        end
      end
      default: begin
        state_nxt = rlevd_pkg::SQ_CLEAR;
      end
    endcase
  end

  // Sequencer outputs: drive the store port
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = wp_r;
    ram_wdata = byte_r;
    unique case (state_r)
      rlevd_pkg::SQ_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      rlevd_pkg::SQ_IDLE: begin
        ram_addr = in_read_address;
      end
      rlevd_pkg::SQ_WRITE: begin
        ram_we = 1'b1;
      end
      rlevd_pkg::SQ_MIRROR: begin
        ram_we   = 1'b1;
        ram_addr = mir_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Next values of decode state, write loop and result registers
  always_comb begin
    phase_nxt         = phase_r;
    wp_nxt            = wp_r;
    run_nxt           = run_r;
    pend_nxt          = pend_r;
    bc_nxt            = bc_r;
    cnt_nxt           = cnt_r;
    byte_nxt          = byte_r;
    mir_nxt           = mir_r;
    res_status_nxt    = res_status_r;
    res_consumed_nxt  = res_consumed_r;
    res_data_nxt      = res_data_r;
    out_status_nxt    = out_status_r;
    out_consumed_nxt  = out_consumed_r;
    out_read_data_nxt = out_read_data_r;
    out_valid_nxt     = out_valid_r && out_stall;
    case (state_r)
      rlevd_pkg::SQ_CLEAR: begin
        // the shared incrementer sweeps the store and wraps back to zero
        wp_nxt = wp_r + 14'd1;
      end
      rlevd_pkg::SQ_IDLE: begin
        if (in_acc) begin
          byte_nxt     = in_stream_byte;
          res_data_nxt = '0;
          if (in_cmd) begin
            res_status_nxt   = rlevd_pkg::ST_READ;
            res_consumed_nxt = '0;
          end else begin
            phase_nxt        = dec_phase;
            wp_nxt           = dec_wp;
            run_nxt          = dec_run;
            pend_nxt         = dec_pend;
            bc_nxt           = dec_bc;
            cnt_nxt          = dec_writes;
            res_status_nxt   = dec_status;
            res_consumed_nxt = dec_consumed;
          end
        end
      end
      rlevd_pkg::SQ_READ: begin
        res_data_nxt = ram_rdata;
      end
      rlevd_pkg::SQ_WRITE: begin
        mir_nxt = rlevd_pkg::mirror_addr(wp_r);
        wp_nxt  = wp_r + 14'd1;
        cnt_nxt = cnt_r - 9'd1;
      end
      rlevd_pkg::SQ_FINISH: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_status_nxt    = res_status_r;
          out_consumed_nxt  = res_consumed_r;
          out_read_data_nxt = res_data_r;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rlevd_pkg::SQ_CLEAR;
      phase_r     <= rlevd_pkg::PH_HDR_LO;
      wp_r        <= '0;
      run_r       <= '0;
      pend_r      <= '0;
      bc_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      wp_r        <= wp_nxt;
      run_r       <= run_nxt;
      pend_r      <= pend_nxt;
      bc_r        <= bc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    byte_r          <= byte_nxt;
    mir_r           <= mir_nxt;
    res_status_r    <= res_status_nxt;
    res_consumed_r  <= res_consumed_nxt;
    res_data_r      <= res_data_nxt;
    out_status_r    <= out_status_nxt;
    out_consumed_r  <= out_consumed_nxt;
    out_read_data_r <= out_read_data_nxt;
  end

  // Video store
  rlevd_ram #(
    .WIDTH(8),
    .DEPTH(rlevd_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

`ifndef SYNTHESIS
  // A mirror write always follows the main write of the same byte
  a_mirror_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rlevd_pkg::SQ_MIRROR) |-> ($past(state_r) == rlevd_pkg::SQ_WRITE))
    else $error("mirror write without a preceding store write");

  // Mirror writes stay inside the palette area
  a_mirror_in_palette: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rlevd_pkg::SQ_MIRROR) |-> (mir_r[13:5] == rlevd_pkg::PAL_BASE[13:5]))
    else $error("mirror address outside the palette area");

  // The clearing pass ends with the write pointer back at zero
  a_clear_ends_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rlevd_pkg::SQ_CLEAR && wp_r == rlevd_pkg::ADDR_MAX)
      |=> (state_r == rlevd_pkg::SQ_IDLE && wp_r == 14'd0))
    else $error("clearing pass did not end cleanly");

  // A write word never leaves the loop with writes outstanding
  a_loop_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rlevd_pkg::SQ_FINISH) |-> (cnt_r == 9'd0 || $past(state_r) != rlevd_pkg::SQ_WRITE))
    else $error("write loop finished with writes remaining");
`endif

endmodule

>>> rtl/rlevd_ram.sv
// Generic single-port RAM with registered read data.
module rlevd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read one address per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
